[sv/occurrence_count_hash_table_defines.svh]
// ----------------------------------------------------------------------------
// Occurrence count hash table assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef OCCURRENCE_COUNT_HASH_TABLE_DEFINES_SVH
`define OCCURRENCE_COUNT_HASH_TABLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OCHT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ocht_checker: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define OCHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ocht_checker: next-cycle property failed");

`endif

[sv/ocht_pkg.sv]
// ----------------------------------------------------------------------------
// Occurrence count hash table package
// Operation and status codes, field widths and fixed constants.
// ----------------------------------------------------------------------------
package ocht_pkg;

    localparam int KEY_W   = 64;
    localparam int CNT_W   = 8;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 3;

    // Key bits folded into the bucket remainder per cycle.
    localparam int RADIX_BITS = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX    = 8'd255;
    localparam logic [CNT_W-1:0] THRESH_RESET = 8'd3;

    // Register index as decoded from paddr[2].
    localparam logic REG_THRESH = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_LOOKUP = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_THRESH  = 3'd1,
        ST_FOUND   = 3'd2,
        ST_MISSING = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

endpackage

[sv/ocht_mod_unit.sv]
// ----------------------------------------------------------------------------
// Bucket remainder unit
// Reduces a key modulo BUCKETS, RADIX_BITS key bits per cycle, MSB first.
// ----------------------------------------------------------------------------
module ocht_mod_unit #(
    parameter int BUCKETS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ocht_pkg::KEY_W-1:0]   i_key,
    output logic                         o_done,
    output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] o_rem
);
    import ocht_pkg::*;

    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int STEPS = KEY_W / RADIX_BITS;
    localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [BW:0] MODULUS = (BW + 1)'(BUCKETS);

    logic [KEY_W-1:0] r_key;
    logic [BW-1:0]    r_rem;
    logic [BW-1:0]    n_rem;
    logic [SW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    // Shift in one key bit at a time; the partial value stays below twice
    // the modulus, so one compare and subtract keeps it reduced.
    always_comb begin
        logic [BW:0]   t_wide;
        logic [BW-1:0] t_rem;
        t_rem = r_rem;
        for (int i = 0; i < RADIX_BITS; i++) begin
            t_wide = {t_rem, r_key[KEY_W-1-i]};
            if (t_wide >= MODULUS) begin
                t_wide = t_wide - MODULUS;
            end
            t_rem = t_wide[BW-1:0];
        end
        n_rem = t_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_key  <= i_key;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_key <= r_key << RADIX_BITS;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[sv/occurrence_count_hash_table.sv]
// ----------------------------------------------------------------------------
// Occurrence count hash table: insert, remove and lookup pass through the shared
// key-modulo unit, then done, row read, row update and result. Clear sweeps every
// bucket row before its result. Ready returns with the result; a stalled result
// holds ready low. Synchronous reset runs a clearing pass over every bucket row.
// ----------------------------------------------------------------------------
module occurrence_count_hash_table #(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ocht_pkg::FUNC_W-1:0]   i_func,
    input  logic [ocht_pkg::KEY_W-1:0]    i_key,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ocht_pkg::STAT_W-1:0]   o_status,
    output logic [ocht_pkg::CNT_W-1:0]    o_occurrences,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ocht_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int KW = WAYS * KEY_W;
    localparam int CW = WAYS * CNT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state;

    logic [FUNC_W-1:0] r_func;
    logic [KEY_W-1:0]  r_key;
    logic [CNT_W-1:0]  r_thresh;
    logic [BW-1:0]     r_clr_idx;
    logic              r_clr_out;
    logic [STAT_W-1:0] r_res_status;
    logic [CNT_W-1:0]  r_res_occ;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [CNT_W-1:0]  r_occ;

    // Bucket row storage: keys, counts and valid bits share one address.
    logic [KW-1:0]   r_mem_key [BUCKETS];
    logic [CW-1:0]   r_mem_cnt [BUCKETS];
    logic [WAYS-1:0] r_mem_vld [BUCKETS];
    logic [KW-1:0]   r_rd_key;
    logic [CW-1:0]   r_rd_cnt;
    logic [WAYS-1:0] r_rd_vld;

    logic            mem_we;
    logic [BW-1:0]   mem_addr;
    logic [KW-1:0]   wr_key;
    logic [CW-1:0]   wr_cnt;
    logic [WAYS-1:0] wr_vld;
    logic [KW-1:0]   upd_key;
    logic [CW-1:0]   upd_cnt;
    logic [WAYS-1:0] upd_vld;

    logic [STAT_W-1:0] res_status;
    logic [CNT_W-1:0]  res_occ;

    logic            in_xfer;
    logic            cfg_wr;
    logic            mod_start;
    logic            mod_done;
    logic [BW-1:0]   bucket;

    assign in_xfer   = i_valid && o_ready;
    assign cfg_wr    = psel && penable && pwrite;
    assign mod_start = in_xfer && (i_func != FUNC_CLEAR);

    ocht_mod_unit #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_key   (i_key),
        .o_done  (mod_done),
        .o_rem   (bucket)
    );

    // Row update: tag compare across all ways, then modify at most one way.
    always_comb begin
        logic [WAYS-1:0]  hit;
        logic             any_hit;
        logic             any_free;
        logic [WW-1:0]    hit_idx;
        logic [WW-1:0]    free_idx;
        logic [CNT_W-1:0] cur_cnt;
        logic [CNT_W-1:0] new_cnt;
        any_hit  = 1'b0;
        any_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        cur_cnt  = '0;
        for (int w = 0; w < WAYS; w++) begin
            hit[w] = r_rd_vld[w] && (r_rd_key[w*KEY_W +: KEY_W] == r_key);
        end
        // Scan downward so the lowest way wins.
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit[w]) begin
                any_hit = 1'b1;
                hit_idx = WW'(w);
            end
            if (!r_rd_vld[w]) begin
                any_free = 1'b1;
                free_idx = WW'(w);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (hit_idx == WW'(w)) begin
                cur_cnt = r_rd_cnt[w*CNT_W +: CNT_W];
            end
        end
        new_cnt = 8'(cur_cnt + 8'd1);

        upd_key    = r_rd_key;
        upd_cnt    = r_rd_cnt;
        upd_vld    = r_rd_vld;
        res_status = ST_OK;
        res_occ    = '0;

        case (r_func)
            FUNC_INSERT: begin
                if (any_hit) begin
                    if (cur_cnt != COUNT_MAX) begin
                        for (int w = 0; w < WAYS; w++) begin
                            if (hit_idx == WW'(w)) begin
                                upd_cnt[w*CNT_W +: CNT_W] = new_cnt;
                            end
                        end
                        res_status = (new_cnt == r_thresh) ? ST_THRESH : ST_OK;
                        res_occ    = new_cnt;
                    end else begin
                        res_occ = COUNT_MAX;
                    end
                end else if (any_free) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (free_idx == WW'(w)) begin
                            upd_key[w*KEY_W +: KEY_W] = r_key;
                            upd_cnt[w*CNT_W +: CNT_W] = 8'd1;
                            upd_vld[w]                = 1'b1;
                        end
                    end
                    res_occ = 8'd1;
                end else begin
                    res_status = ST_FULL;
                end
            end
            FUNC_REMOVE: begin
                if (any_hit) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (hit_idx == WW'(w)) begin
                            upd_vld[w] = 1'b0;
                        end
                    end
                    res_status = ST_FOUND;
                end else begin
                    res_status = ST_MISSING;
                end
            end
            FUNC_LOOKUP: begin
                if (any_hit) begin
                    res_status = ST_FOUND;
                    res_occ    = cur_cnt;
                end else begin
                    res_status = ST_MISSING;
                end
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    // Write port: clearing sweep or the updated row.
    always_comb begin
        mem_we   = 1'b0;
        mem_addr = bucket;
        wr_key   = upd_key;
        wr_cnt   = upd_cnt;
        wr_vld   = upd_vld;
        case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr_idx;
                wr_key   = '0;
                wr_cnt   = '0;
                wr_vld   = '0;
            end
            S_EXEC: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_key[mem_addr] <= wr_key;
            r_mem_cnt[mem_addr] <= wr_cnt;
            r_mem_vld[mem_addr] <= wr_vld;
        end
        r_rd_key <= r_mem_key[bucket];
        r_rd_cnt <= r_mem_cnt[bucket];
        r_rd_vld <= r_mem_vld[bucket];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_clr_out   <= 1'b0;
            r_out_valid <= 1'b0;
            r_thresh    <= THRESH_RESET;
        end else begin
            if (cfg_wr && (paddr[2] == REG_THRESH)) begin
                r_thresh <= pwdata[CNT_W-1:0];
            end
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_clr_idx == BW'(BUCKETS - 1)) begin
                        r_clr_idx <= '0;
                        r_state   <= r_clr_out ? S_DONE : S_IDLE;
                    end else begin
                        r_clr_idx <= r_clr_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_func       <= i_func;
                        r_key        <= i_key;
                        r_res_status <= ST_OK;
                        r_res_occ    <= '0;
                        if (i_func == FUNC_CLEAR) begin
                            r_clr_out <= 1'b1;
                            r_clr_idx <= '0;
                            r_state   <= S_CLEAR;
                        end else begin
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_res_status <= res_status;
                    r_res_occ    <= res_occ;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    // Hold until the output register is free.
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_status    <= r_res_status;
                        r_occ       <= r_res_occ;
                        r_clr_out   <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_occurrences = r_occ;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_THRESH) ? {24'b0, r_thresh} : 32'b0;

endmodule

[sv/ocht_checker.sv]
// ----------------------------------------------------------------------------
// Occurrence count hash table port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "occurrence_count_hash_table_defines.svh"

module ocht_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [ocht_pkg::STAT_W-1:0]   o_status,
    input logic [ocht_pkg::CNT_W-1:0]    o_occurrences,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [2:0]                    paddr,
    input logic [31:0]                   pwdata,
    input logic [31:0]                   prdata,
    input logic                          pready
);
    import ocht_pkg::*;

    logic        out_stall;
    logic        in_xfer;
    logic        out_absent;
    logic        thresh_sel;
    logic        thresh_wr;
    logic [31:0] thresh_word;

    assign out_stall   = o_valid && !i_ready;
    assign in_xfer     = i_valid && o_ready;
    assign out_absent  = o_valid && ((o_status == ST_MISSING) || (o_status == ST_FULL));
    assign thresh_sel  = (paddr[2] == REG_THRESH);
    assign thresh_wr   = psel && penable && pwrite && pready && thresh_sel;
    assign thresh_word = {24'b0, pwdata[CNT_W-1:0]};

    // A stalled result holds its value.
    `OCHT_ASSERT_NEXT(a_out_hold, out_stall, o_valid && $stable({o_status, o_occurrences}))

    // One item at a time: ready drops after every input transfer.
    `OCHT_ASSERT_NEXT(a_one_at_a_time, in_xfer, !o_ready)

    // Absent keys and full buckets report no occurrences.
    `OCHT_ASSERT_SAME(a_absent_zero, out_absent, o_occurrences == 8'd0)

    // A threshold write reads back on the next cycle.
    `OCHT_ASSERT_NEXT(a_thresh_readback, thresh_wr, !thresh_sel || prdata == $past(thresh_word))

endmodule

bind occurrence_count_hash_table ocht_checker u_ocht_checker (.*);

[tb/occurrence_count_hash_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occurrence count hash table testbench
// Drives insert, remove, clear and lookup transfers with random bursts, gaps
// and output stalls. A directed table covers reset state, bucket overflow,
// the threshold and the key extremes. Random phases run under several repeat
// thresholds, including saturation of one hot key. An in-bench table model
// predicts the results that the table does not fix; all are compared in order.
// ----------------------------------------------------------------------------
module occurrence_count_hash_table_tb;
    import ocht_pkg::*;

    localparam int BUCKETS = 1024;
    localparam int WAYS    = 4;
    localparam int ENTRIES = BUCKETS * WAYS;

    localparam logic [2:0] ADDR_THRESH = 3'd0;
    localparam logic [2:0] ADDR_SPARE  = 3'd4;

    typedef struct packed {
        t_status            status;
        logic [CNT_W-1:0]   occ;
    } t_result;

    typedef struct packed {
        t_func              func;
        logic [KEY_W-1:0]   key;
        logic               fixed;
        t_status            status;
        logic [CNT_W-1:0]   occ;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [FUNC_W-1:0]     i_func;
    logic [KEY_W-1:0]      i_key;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [STAT_W-1:0]     o_status;
    logic [CNT_W-1:0]      o_occurrences;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // Table model state
    logic [KEY_W-1:0]      key_mem [ENTRIES];
    logic [CNT_W-1:0]      cnt_mem [ENTRIES];
    bit                    vld_mem [ENTRIES];
    logic [CNT_W-1:0]      thresh_q;

    t_result               result_q [$];
    int                    err_cnt = 0;
    int                    burst_left = 0;
    int                    n_func [4] = '{0, 0, 0, 0};
    int                    n_full = 0;
    int                    n_thresh = 0;
    int                    n_sat = 0;

    logic [53:0]           pool_hi [6];
    logic [9:0]            pool_bk [3];
    logic [KEY_W-1:0]      hot_key;

    t_row dir_tbl [24] = '{
        '{FUNC_LOOKUP, 64'd0,                   1'b1, ST_MISSING, 8'd0},
        '{FUNC_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_MISSING, 8'd0},
        '{FUNC_INSERT, 64'd0,                   1'b1, ST_OK,      8'd1},
        '{FUNC_INSERT, 64'd0,                   1'b1, ST_OK,      8'd2},
        '{FUNC_INSERT, 64'd0,                   1'b1, ST_THRESH,  8'd3},
        '{FUNC_INSERT, 64'd0,                   1'b1, ST_OK,      8'd4},
        '{FUNC_LOOKUP, 64'd0,                   1'b1, ST_FOUND,   8'd4},
        '{FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_OK,      8'd1},
        '{FUNC_INSERT, 64'd1024,                1'b1, ST_OK,      8'd1},
        '{FUNC_INSERT, 64'd2048,                1'b1, ST_OK,      8'd1},
        '{FUNC_INSERT, 64'd3072,                1'b1, ST_OK,      8'd1},
        '{FUNC_INSERT, 64'd4096,                1'b1, ST_FULL,    8'd0},
        '{FUNC_REMOVE, 64'd1024,                1'b1, ST_FOUND,   8'd0},
        '{FUNC_INSERT, 64'd4096,                1'b1, ST_OK,      8'd1},
        '{FUNC_LOOKUP, 64'd1024,                1'b1, ST_MISSING, 8'd0},
        '{FUNC_REMOVE, 64'd1024,                1'b1, ST_MISSING, 8'd0},
        '{FUNC_LOOKUP, 64'd4096,                1'b1, ST_FOUND,   8'd1},
        '{FUNC_INSERT, 64'h8000_0000_0000_0000, 1'b1, ST_FULL,    8'd0},
        '{FUNC_CLEAR,  64'h5555_5555_5555_5555, 1'b1, ST_OK,      8'd0},
        '{FUNC_LOOKUP, 64'd0,                   1'b1, ST_MISSING, 8'd0},
        '{FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_MISSING, 8'd0},
        '{FUNC_INSERT, 64'h8000_0000_0000_0000, 1'b1, ST_OK,      8'd1},
        '{FUNC_INSERT, 64'h8000_0000_0000_0000, 1'b0, ST_OK,      8'd0},
        '{FUNC_LOOKUP, 64'h5555_5555_5555_5555, 1'b0, ST_OK,      8'd0}
    };

    occurrence_count_hash_table #(
        .BUCKETS       (BUCKETS),
        .WAYS          (WAYS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_key         (i_key),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_occurrences (o_occurrences),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one operation to the table model and return its result.
    function automatic t_result apply_op(t_func f, logic [KEY_W-1:0] k);
        int      base;
        int      hit;
        int      free_w;
        t_result r;
        base   = int'(k % BUCKETS) * WAYS;
        hit    = -1;
        free_w = -1;
        for (int w = 0; w < WAYS; w++) begin
            if (vld_mem[base + w] && key_mem[base + w] == k && hit < 0) hit = w;
            if (!vld_mem[base + w] && free_w < 0) free_w = w;
        end
        r.status = ST_OK;
        r.occ    = '0;
        case (f)
            FUNC_INSERT: begin
                if (hit >= 0) begin
                    if (cnt_mem[base + hit] < COUNT_MAX) begin
                        cnt_mem[base + hit] = cnt_mem[base + hit] + 1'b1;
                        if (cnt_mem[base + hit] == thresh_q) r.status = ST_THRESH;
                    end
                    r.occ = cnt_mem[base + hit];
                end else if (free_w >= 0) begin
                    key_mem[base + free_w] = k;
                    cnt_mem[base + free_w] = 8'd1;
                    vld_mem[base + free_w] = 1'b1;
                    r.occ = 8'd1;
                end else begin
                    r.status = ST_FULL;
                end
            end
            FUNC_REMOVE: begin
                if (hit >= 0) begin
                    vld_mem[base + hit] = 1'b0;
                    r.status = ST_FOUND;
                end else begin
                    r.status = ST_MISSING;
                end
            end
            FUNC_CLEAR: begin
                for (int e = 0; e < ENTRIES; e++) vld_mem[e] = 1'b0;
            end
            default: begin
                if (hit >= 0) begin
                    r.status = ST_FOUND;
                    r.occ    = cnt_mem[base + hit];
                end else begin
                    r.status = ST_MISSING;
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_op(t_func f, logic [KEY_W-1:0] k, logic fixed, t_status es,
                           logic [CNT_W-1:0] eo);
        t_result r;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_func  <= f;
        i_key   <= k;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        r = apply_op(f, k);
        if (fixed) begin
            r.status = es;
            r.occ    = eo;
        end
        result_q.push_back(r);
        n_func[f]++;
        if (r.status == ST_FULL) n_full++;
        if (r.status == ST_THRESH) n_thresh++;
        if (f == FUNC_INSERT && r.occ == COUNT_MAX) n_sat++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // End the burst: drop valid and idle for a while.
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(0, 25)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic apb_access(logic wr, logic [2:0] a, logic [31:0] d,
                              output logic [31:0] rd);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        if (wr && a == ADDR_THRESH) thresh_q = d[CNT_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_reg(logic [2:0] a, logic [31:0] d);
        logic [31:0] rd;
        apb_access(1'b1, a, d, rd);
    endtask

    task automatic check_thresh();
        logic [31:0] rd;
        apb_access(1'b0, ADDR_THRESH, 32'd0, rd);
        if (rd[CNT_W-1:0] !== thresh_q) begin
            $display("%0t: threshold readback expected %0d got %0d", $time, thresh_q,
                     rd[CNT_W-1:0]);
            err_cnt++;
        end
    endtask

    // Hold valid low until every expected result has come back.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        burst_left = 0;
        while (result_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
        return {pool_hi[$urandom_range(0, 5)], pool_bk[$urandom_range(0, 2)]};
    endfunction

    task automatic random_run(int n, bit hot);
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (hot && sel < 90) begin
                send_op(FUNC_INSERT, hot_key, 1'b0, ST_OK, 8'd0);
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 50)
                    send_op(FUNC_INSERT, pick_key(), 1'b0, ST_OK, 8'd0);
                else if (sel < 75 || (hot && sel >= 96))
                    send_op(FUNC_LOOKUP, pick_key(), 1'b0, ST_OK, 8'd0);
                else if (sel < 96)
                    send_op(FUNC_REMOVE, pick_key(), 1'b0, ST_OK, 8'd0);
                else
                    send_op(FUNC_CLEAR, pick_key(), 1'b0, ST_OK, 8'd0);
            end
        end
    endtask

    // Output stalls: short random stalls with occasional calm stretches.
    int stall_left = 0;
    int calm_left  = 0;
    always @(negedge i_clk) begin
        if (calm_left > 0) begin
            calm_left--;
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            case ($urandom_range(0, 9))
                0:       calm_left  = $urandom_range(50, 200);
                1, 2, 3: stall_left = $urandom_range(1, 8);
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result status %0d occurrences %0d", $time,
                         o_status, o_occurrences);
                err_cnt++;
            end else begin
                exp_r = result_q.pop_front();
                if (o_status !== exp_r.status) begin
                    $display("%0t: status expected %0d got %0d", $time, exp_r.status,
                             o_status);
                    err_cnt++;
                end
                if (o_occurrences !== exp_r.occ) begin
                    $display("%0t: occurrences expected %0d got %0d", $time, exp_r.occ,
                             o_occurrences);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #50_000_000;
        $display("occurrence_count_hash_table_tb: errors");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func  = FUNC_INSERT;
        i_key   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        for (int e = 0; e < ENTRIES; e++) vld_mem[e] = 1'b0;
        thresh_q = THRESH_RESET;
        for (int j = 0; j < 6; j++) pool_hi[j] = 54'({$urandom, $urandom});
        for (int j = 0; j < 3; j++) pool_bk[j] = 10'($urandom_range(0, 511));
        hot_key = {22'($urandom), $urandom, 10'($urandom_range(512, 1023))};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset threshold. Ready holds off during the
        // clearing pass after reset.
        check_thresh();
        foreach (dir_tbl[i])
            send_op(dir_tbl[i].func, dir_tbl[i].key, dir_tbl[i].fixed, dir_tbl[i].status,
                    dir_tbl[i].occ);
        drain();

        // Lowest legal threshold; upper data bits must be dropped.
        write_reg(ADDR_THRESH, {16'($urandom_range(1, 16'hFFFF)), 16'h0002});
        check_thresh();
        random_run(150, 1'b0);
        drain();

        // Highest threshold: drive one key up to saturation.
        write_reg(ADDR_THRESH, 32'hFFFF_FFFF);
        check_thresh();
        random_run(300, 1'b1);
        drain();

        // Unmapped register must not disturb the threshold.
        write_reg(ADDR_SPARE, $urandom);
        check_thresh();
        write_reg(ADDR_THRESH, {24'($urandom), 7'd0, 1'($urandom_range(0, 1))});
        check_thresh();
        random_run(50, 1'b0);
        drain();

        write_reg(ADDR_THRESH, 32'($urandom_range(2, 255)));
        check_thresh();
        random_run(50, 1'b0);
        drain();

        repeat (40) @(posedge i_clk);
        $display("ran %0d transfers: insert %0d, remove %0d, clear %0d, lookup %0d",
                 n_func[0] + n_func[1] + n_func[2] + n_func[3], n_func[FUNC_INSERT],
                 n_func[FUNC_REMOVE], n_func[FUNC_CLEAR], n_func[FUNC_LOOKUP]);
        $display("bucket full %0d, threshold hits %0d, saturated inserts %0d",
                 n_full, n_thresh, n_sat);
        if (err_cnt == 0) begin
            $display("occurrence_count_hash_table_tb: clean");
        end else begin
            $display("occurrence_count_hash_table_tb: errors");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/ocht_pkg.sv
sv/ocht_mod_unit.sv
sv/occurrence_count_hash_table.sv
sv/ocht_checker.sv
tb/occurrence_count_hash_table_tb.sv
